[hw/rtl/rtk_pkg.sv]
// shared types and constants for the relay autotuner
// widths, request and status codes, controller/datapath handshake structs
// no dependencies
package rtk_pkg;

	localparam int REQ_W      = 2;
	localparam int SIG_W      = 24;
	localparam int TIME_W     = 32;
	localparam int AMP_W      = 16;
	localparam int HYST_W     = 23;
	localparam int DRIVE_W    = 17;
	localparam int STATUS_W   = 3;
	localparam int GAIN_W     = 32;
	localparam int PERIOD_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int PERIODS_DEF = 3;
	localparam int TIMEOUT_DEF = 30000;

	localparam logic [AMP_W-1:0]  AMP_RESET  = 16'd4096;
	localparam logic [HYST_W-1:0] HYST_RESET = 23'd410;

	// pi in unsigned Q2.24
	localparam int PI_W = 26;
	localparam logic [PI_W-1:0] PI_Q24 = 26'h3243F6B;

	// Ku = 8*d*2^40 / (pp*pi_q24): the dividend is d << 43, i.e. d << 11 above a 32-bit
	// quotient field
	localparam int KU_NUM_SHIFT = 11;
	localparam int DEN_W        = SIG_W + PI_W;
	localparam int QUO_W        = 32;

	localparam int PERIOD_MAX    = 65535;
	localparam int MIN_PERIOD_MS = 50;
	localparam int PP_X50_MIN    = 4096;

	localparam logic [2:0] UP_FLIP_ARM   = 3'd2;
	localparam logic [2:0] UP_FLIP_TRACK = 3'd3;
	localparam logic [2:0] UP_FLIP_SAT   = 3'd4;

	typedef enum logic [REQ_W-1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_BEGIN  = 2'd1,
		REQ_CANCEL = 2'd2
	} req_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_IDLE       = 3'd0,
		STATUS_RUNNING    = 3'd1,
		STATUS_DONE       = 3'd2,
		STATUS_FAIL_SMALL = 3'd3,
		STATUS_FAIL_TIME  = 3'd4
	} tune_status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DRIVE_AMP = 2'd0,
		CFG_HYST      = 2'd1
	} cfg_reg_t;

	typedef struct packed {
		logic accept;
		logic mul;
		logic ku_start;
		logic take_ku;
		logic take_tu;
		logic load_out;
	} rtk_cmd_t;

	typedef struct packed {
		logic need_div;
		logic div_done;
	} rtk_stat_t;

endpackage

[hw/rtl/rtk_ifs.sv]
// channel interfaces of the relay autotuner: request, result, register write
// depends on rtk_pkg
interface rtk_req_if import rtk_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic signed [SIG_W-1:0]  error_value;
	logic signed [SIG_W-1:0]  measured_value;
	logic [TIME_W-1:0]        timestamp_ms;

	modport source (output valid, req_type, error_value, measured_value, timestamp_ms,
		input ready);
	modport sink (input valid, req_type, error_value, measured_value, timestamp_ms,
		output ready);
endinterface

interface rtk_res_if import rtk_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive;
	logic [STATUS_W-1:0]       status;
	logic [GAIN_W-1:0]         ultimate_gain;
	logic [PERIOD_W-1:0]       ultimate_period_ms;

	modport source (output valid, drive, status, ultimate_gain, ultimate_period_ms,
		input ready);
	modport sink (input valid, drive, status, ultimate_gain, ultimate_period_ms,
		output ready);
endinterface

interface rtk_cfg_if import rtk_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[hw/rtl/rtk_div.sv]
// restoring divider, one quotient bit per cycle, saturating 32-bit quotient
// depends on rtk_pkg
module rtk_div import rtk_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DEN_W-1:0] init_rem,
	input  logic [QUO_W-1:0] low_num,
	input  logic [DEN_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	localparam int CNT_W = $clog2(QUO_W + 1);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] div_q;
	logic [QUO_W-1:0] num_q;
	logic             sat_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             fits;

	always_comb begin
		trial = {rem_q, num_q[QUO_W-1]};
		diff  = trial - {1'b0, div_q};
		fits  = trial >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(QUO_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// quotient bits shift in behind the dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= init_rem;
			num_q <= low_num;
			div_q <= divisor;
			sat_q <= init_rem >= divisor;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q <= {num_q[QUO_W-2:0], fits};
		end
	end

	assign done     = busy_q && (cnt_q == '0);
	assign quotient = sat_q ? '1 : num_q;

endmodule

[hw/rtl/rtk_dp.sv]
// datapath of the relay autotuner: registers, relay and period tracking,
// den multiplier, divider and output register; depends on rtk_pkg and rtk_div
module rtk_dp import rtk_pkg::*; #(
	parameter int PERIODS_AVERAGED = PERIODS_DEF,
	parameter int TIMEOUT_MS       = TIMEOUT_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rtk_cmd_t                  cmd,
	output rtk_stat_t                 stat,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic [REQ_W-1:0]          req_type,
	input  logic signed [SIG_W-1:0]   error_value,
	input  logic signed [SIG_W-1:0]   measured_value,
	input  logic [TIME_W-1:0]         timestamp_ms,
	output logic signed [DRIVE_W-1:0] drive,
	output logic [STATUS_W-1:0]       status,
	output logic [GAIN_W-1:0]         ultimate_gain,
	output logic [PERIOD_W-1:0]       ultimate_period_ms
);

	localparam int CNT_W = $clog2(PERIODS_AVERAGED + 1);
	localparam int SUM_W = $clog2(PERIODS_AVERAGED * PERIOD_MAX + PERIODS_AVERAGED / 2 + 1);
	localparam int PPX_W = SIG_W + 6;
	localparam logic [CNT_W-1:0]  CNT_FULL    = CNT_W'(PERIODS_AVERAGED);
	localparam logic [SUM_W-1:0]  SUM_MIN     = SUM_W'(MIN_PERIOD_MS * PERIODS_AVERAGED);
	localparam logic [SUM_W-1:0]  SUM_HALF    = SUM_W'(PERIODS_AVERAGED / 2);
	localparam logic [TIME_W-1:0] TIMEOUT_LIM = TIME_W'(TIMEOUT_MS);
	localparam logic [TIME_W-1:0] DT_MAX      = TIME_W'(PERIOD_MAX);

	// Tu average by reciprocal multiply, exact for every sum below 2^SUM_W
	localparam int TU_SHIFT = SUM_W + 3;
	localparam int TU_RW    = TU_SHIFT + 1;
	localparam int TU_PW    = SUM_W + TU_RW;
	localparam logic [TU_RW-1:0] TU_RECIP = TU_RW'(((64'd1 << TU_SHIFT) +
		64'(PERIODS_AVERAGED - 1)) / 64'(PERIODS_AVERAGED));

	// configuration
	logic [AMP_W-1:0]  amp_q;
	logic [HYST_W-1:0] hyst_q;

	// run state
	logic                    run_q;
	logic                    relay_q;
	logic [2:0]              up_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [SUM_W-1:0]        sum_q;
	logic [TIME_W-1:0]       last_q;
	logic [TIME_W-1:0]       start_q;
	logic signed [SIG_W-1:0] min_q;
	logic signed [SIG_W-1:0] max_q;
	logic [GAIN_W-1:0]       gain_q;
	logic [PERIOD_W-1:0]     period_q;
	logic [DEN_W-1:0]        den_q;

	// result held until the output register is free
	logic signed [DRIVE_W-1:0] res_drive_q;
	logic [STATUS_W-1:0]       res_status_q;
	logic signed [DRIVE_W-1:0] out_drive_q;
	logic [STATUS_W-1:0]       out_status_q;
	logic [GAIN_W-1:0]         out_gain_q;
	logic [PERIOD_W-1:0]       out_period_q;

	// next-state of a sample step
	logic signed [SIG_W:0]     e_x;
	logic signed [SIG_W:0]     h_x;
	logic                      flip_dn;
	logic                      flip_up;
	logic                      relay_n;
	logic [2:0]                up_n;
	logic [CNT_W-1:0]          cnt_n;
	logic [SUM_W-1:0]          sum_n;
	logic [TIME_W-1:0]         last_n;
	logic signed [SIG_W-1:0]   min_n;
	logic signed [SIG_W-1:0]   max_n;
	logic [TIME_W-1:0]         dt_raw;
	logic [PERIOD_W-1:0]       dt;
	logic [SIG_W-1:0]          pp_n;
	logic [SIG_W-1:0]          pp_r;
	logic [PPX_W-1:0]          pp_x50;
	logic                      finish;
	logic                      ok;
	logic [TIME_W-1:0]         elapsed;
	logic                      timed_out;
	logic signed [DRIVE_W-1:0] mag;
	logic signed [DRIVE_W-1:0] drv_n;
	logic [STATUS_W-1:0]       samp_status;
	logic                      run_n;

	// Tu rounding
	logic [SUM_W-1:0]          tu_num;
	logic [TU_PW-1:0]          tu_prod;

	// divider hookup
	logic             div_start;
	logic [DEN_W-1:0] div_init;
	logic [QUO_W-1:0] div_low;
	logic [DEN_W-1:0] div_den;
	logic             div_done;
	logic [QUO_W-1:0] div_quo;

	always_comb begin
		e_x     = {error_value[SIG_W-1], error_value};
		h_x     = {2'b00, hyst_q};
		flip_dn = relay_q && (e_x < -h_x);
		flip_up = !relay_q && (e_x > h_x);
		relay_n = relay_q;
		up_n    = up_q;
		cnt_n   = cnt_q;
		sum_n   = sum_q;
		last_n  = last_q;
		min_n   = min_q;
		max_n   = max_q;
		dt_raw  = timestamp_ms - last_q;
		dt      = (dt_raw > DT_MAX) ? PERIOD_W'(PERIOD_MAX) : dt_raw[PERIOD_W-1:0];

		if (flip_dn) begin
			relay_n = 1'b0;
		end else if (flip_up) begin
			relay_n = 1'b1;
			if (up_q < UP_FLIP_SAT) begin
				up_n = up_q + 3'd1;
			end
			if (up_q == UP_FLIP_ARM) begin
				// measurement starts on this upward flip
				min_n  = measured_value;
				max_n  = measured_value;
				last_n = timestamp_ms;
			end else if (up_q >= UP_FLIP_TRACK) begin
				if (cnt_q < CNT_FULL) begin
					sum_n = sum_q + SUM_W'(dt);
					cnt_n = cnt_q + 1'b1;
				end
				last_n = timestamp_ms;
			end
		end

		if (up_n >= UP_FLIP_TRACK) begin
			if (measured_value < min_n) begin
				min_n = measured_value;
			end
			if (measured_value > max_n) begin
				max_n = measured_value;
			end
		end

		pp_n      = SIG_W'(max_n - min_n);
		pp_x50    = PPX_W'(pp_n) * PPX_W'(50);
		ok        = (pp_x50 > PPX_W'(PP_X50_MIN)) && (sum_n > SUM_MIN);
		finish    = cnt_n >= CNT_FULL;
		elapsed   = timestamp_ms - start_q;
		timed_out = elapsed > TIMEOUT_LIM;
		mag       = DRIVE_W'({1'b0, amp_q});
		drv_n     = relay_n ? mag : -mag;

		// completion takes priority over the timeout
		if (finish) begin
			samp_status = ok ? STATUS_DONE : STATUS_FAIL_SMALL;
		end else if (timed_out) begin
			samp_status = STATUS_FAIL_TIME;
		end else begin
			samp_status = STATUS_RUNNING;
		end
		run_n = !(finish || timed_out);
	end

	assign stat.need_div = (req_type == REQ_SAMPLE) && run_q && finish && ok;
	assign stat.div_done = div_done;

	assign tu_num  = sum_q + SUM_HALF;
	assign tu_prod = TU_PW'(tu_num) * TU_PW'(TU_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amp_q  <= AMP_RESET;
			hyst_q <= HYST_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DRIVE_AMP: amp_q  <= cfg_data[AMP_W-1:0];
				CFG_HYST:      hyst_q <= cfg_data[HYST_W-1:0];
				default:       ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			relay_q  <= 1'b1;
			up_q     <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			last_q   <= '0;
			start_q  <= '0;
			min_q    <= '0;
			max_q    <= '0;
			gain_q   <= '0;
			period_q <= '0;
		end else begin
			if (cmd.accept) begin
				case (req_type)
					REQ_BEGIN: begin
						run_q   <= 1'b1;
						relay_q <= 1'b1;
						up_q    <= '0;
						cnt_q   <= '0;
						sum_q   <= '0;
						last_q  <= '0;
						min_q   <= '0;
						max_q   <= '0;
						start_q <= timestamp_ms;
					end
					REQ_CANCEL: begin
						run_q <= 1'b0;
					end
					REQ_SAMPLE: begin
						if (run_q) begin
							run_q   <= run_n;
							relay_q <= relay_n;
							up_q    <= up_n;
							cnt_q   <= cnt_n;
							sum_q   <= sum_n;
							last_q  <= last_n;
							min_q   <= min_n;
							max_q   <= max_n;
						end
					end
					default: ;
				endcase
			end
			if (cmd.take_ku) begin
				gain_q <= div_quo;
			end
			if (cmd.take_tu) begin
				period_q <= tu_prod[TU_SHIFT +: PERIOD_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			case (req_type)
				REQ_BEGIN: begin
					res_drive_q  <= '0;
					res_status_q <= STATUS_RUNNING;
				end
				REQ_CANCEL: begin
					res_drive_q  <= '0;
					res_status_q <= STATUS_IDLE;
				end
				REQ_SAMPLE: begin
					res_drive_q  <= run_q ? drv_n : '0;
					res_status_q <= run_q ? samp_status : STATUS_IDLE;
				end
				default: begin
					res_drive_q  <= '0;
					res_status_q <= run_q ? STATUS_RUNNING : STATUS_IDLE;
				end
			endcase
		end
	end

	// denominator pp * pi, registered ahead of the divider
	assign pp_r = SIG_W'(max_q - min_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			den_q <= {{PI_W{1'b0}}, pp_r} * {{SIG_W{1'b0}}, PI_Q24};
		end
	end

	assign div_start = cmd.ku_start;
	assign div_init  = DEN_W'({amp_q, {KU_NUM_SHIFT{1'b0}}});
	assign div_low   = '0;
	assign div_den   = den_q;

	rtk_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.init_rem (div_init),
		.low_num  (div_low),
		.divisor  (div_den),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_drive_q  <= res_drive_q;
			out_status_q <= res_status_q;
			out_gain_q   <= gain_q;
			out_period_q <= period_q;
		end
	end

	assign drive              = out_drive_q;
	assign status             = out_status_q;
	assign ultimate_gain      = out_gain_q;
	assign ultimate_period_ms = out_period_q;

endmodule

[hw/rtl/rtk_ctrl.sv]
// controller of the relay autotuner: sequences accept, the Ku division and
// result hand-off, owns the output valid; depends on rtk_pkg
module rtk_ctrl import rtk_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  rtk_stat_t stat,
	output rtk_cmd_t  cmd
);

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_MUL     = 5'b00010,
		ST_KU_GO   = 5'b00100,
		ST_KU_WAIT = 5'b01000,
		ST_PUSH    = 5'b10000
	} ctrl_state_t;

	ctrl_state_t state_q;
	ctrl_state_t state_n;
	logic        out_valid_q;

	always_comb begin
		cmd     = '0;
		state_n = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_n    = stat.need_div ? ST_MUL : ST_PUSH;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_n = ST_KU_GO;
			end
			ST_KU_GO: begin
				cmd.ku_start = 1'b1;
				state_n      = ST_KU_WAIT;
			end
			ST_KU_WAIT: begin
				// Tu comes from the reciprocal multiply, ready alongside Ku
				if (stat.div_done) begin
					cmd.take_ku = 1'b1;
					cmd.take_tu = 1'b1;
					state_n     = ST_PUSH;
				end
			end
			ST_PUSH: begin
				// output register free or emptied at this edge
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

[hw/rtl/relay_autotune_ku_tu_unit.sv]
// top level of the relay autotuner: controller, datapath and channel wiring
// depends on rtk_pkg, rtk_ifs, rtk_ctrl, rtk_dp
//
// channel | dir | transaction carries
// req     | in  | req_type, error_value, measured_value, timestamp_ms
// res     | out | drive, status, ultimate_gain, ultimate_period_ms
// cfg     | in  | index, data (register write, always ready)
//
// every request gives one result transaction; most pass through accept, then output load,
// the sample that closes a successful run through accept, den multiply, divider start,
// the restoring divider and then load
// a new request is taken once the previous result has moved to the output
// register, so a stalled result holds back at most one request
// reset is asynchronous and needs no clearing pass
module relay_autotune_ku_tu_unit import rtk_pkg::*; #(
	parameter int PERIODS_AVERAGED = PERIODS_DEF,
	parameter int TIMEOUT_MS       = TIMEOUT_DEF
) (
	input logic       clk,
	input logic       arst_n,
	rtk_req_if.sink   req,
	rtk_res_if.source res,
	rtk_cfg_if.sink   cfg
);

	rtk_cmd_t  cmd;
	rtk_stat_t stat;

	assign cfg.ready = 1'b1;

	rtk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rtk_dp #(
		.PERIODS_AVERAGED (PERIODS_AVERAGED),
		.TIMEOUT_MS       (TIMEOUT_MS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.stat               (stat),
		.cfg_we             (cfg.valid),
		.cfg_index          (cfg.index),
		.cfg_data           (cfg.data),
		.req_type           (req.req_type),
		.error_value        (req.error_value),
		.measured_value     (req.measured_value),
		.timestamp_ms       (req.timestamp_ms),
		.drive              (res.drive),
		.status             (res.status),
		.ultimate_gain      (res.ultimate_gain),
		.ultimate_period_ms (res.ultimate_period_ms)
	);

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for the relay autotuner: random relay runs, idle noise, register writes
// predicts every result transaction from its own model of the tuner; needs rtk_pkg, rtk_ifs
module testbench;
	import rtk_pkg::*;

	localparam int LIMIT_CYCLES = 500000;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 300;
	localparam int CHUNK_ITEMS  = 250;
	localparam int CHUNKS       = 6;

	typedef struct {
		req_kind_t               kind;
		logic signed [SIG_W-1:0] err;
		logic signed [SIG_W-1:0] meas;
		logic [TIME_W-1:0]       stamp;
	} tune_req_t;

	typedef struct {
		logic signed [DRIVE_W-1:0] drive;
		tune_status_t              status;
		logic [GAIN_W-1:0]         gain;
		logic [PERIOD_W-1:0]       tu_ms;
	} tune_result_t;

	logic clk;
	logic arst_n;

	rtk_req_if req();
	rtk_res_if res();
	rtk_cfg_if cfg();

	relay_autotune_ku_tu_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res),
		.cfg    (cfg)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	tune_req_t    pending[$];
	tune_result_t expected[$];
	tune_req_t    on_bus;
	int           queued = 0;
	int           accepted_reqs = 0;
	int           mismatches = 0;
	int unsigned  send_gap_pct = 6;
	int unsigned  recv_stall_pct = 81;
	int           pressure_at = 32'h7fff_ffff;
	int           hold_left = 0;
	bit           hold_used = 1'b0;
	int           cycles = 0;
	bit [31:0]    gen_ms = '0;

	// tuner model: configuration and run state
	logic [AMP_W-1:0]  amp_q = AMP_RESET;
	logic [HYST_W-1:0] hyst_q = HYST_RESET;
	bit                running = 1'b0;
	bit                relay_hi = 1'b1;
	int unsigned       rises = 0;
	int unsigned       nper = 0;
	bit [31:0]         per_ms [PERIODS_DEF];
	bit [31:0]         last_rise_ms = '0;
	bit [31:0]         run_start_ms = '0;
	int                peak_lo = 0;
	int                peak_hi = 0;
	bit [GAIN_W-1:0]   gain_q = '0;
	bit [PERIOD_W-1:0] tu_q = '0;

	function automatic void predict_tune(tune_req_t r);
		tune_result_t           o;
		int                     e;
		int                     y;
		longint                 h;
		bit [31:0]              dt;
		longint unsigned        sum;
		longint unsigned        pp;
		longint unsigned        num;
		longint unsigned        den;
		longint unsigned        ku;
		logic signed [DRIVE_W-1:0] mag;
		e = r.err;
		y = r.meas;
		h = hyst_q;
		mag = {1'b0, amp_q};
		o.drive = '0;
		if (r.kind == REQ_BEGIN) begin
			running = 1'b1;
			relay_hi = 1'b1;
			rises = 0;
			nper = 0;
			last_rise_ms = '0;
			peak_lo = 0;
			peak_hi = 0;
			run_start_ms = r.stamp;
			o.status = STATUS_RUNNING;
		end else if (r.kind == REQ_CANCEL) begin
			running = 1'b0;
			o.status = STATUS_IDLE;
		end else if (r.kind != REQ_SAMPLE || !running) begin
			o.status = running ? STATUS_RUNNING : STATUS_IDLE;
		end else begin
			if (relay_hi && e < -h) begin
				relay_hi = 1'b0;
			end else if (!relay_hi && e > h) begin
				relay_hi = 1'b1;
				// third rising flip arms tracking, later ones close a period
				if (rises == 2) begin
					peak_lo = y;
					peak_hi = y;
					last_rise_ms = r.stamp;
				end else if (rises >= 3) begin
					dt = r.stamp - last_rise_ms;
					if (dt > PERIOD_MAX)
						dt = PERIOD_MAX;
					if (nper < PERIODS_DEF) begin
						per_ms[nper] = dt;
						nper++;
					end
					last_rise_ms = r.stamp;
				end
				if (rises < 4)
					rises++;
			end
			if (rises >= 3) begin
				if (y < peak_lo)
					peak_lo = y;
				if (y > peak_hi)
					peak_hi = y;
			end
			o.drive = relay_hi ? mag : -mag;
			o.status = STATUS_RUNNING;
			if (nper >= PERIODS_DEF) begin
				sum = 0;
				for (int i = 0; i < PERIODS_DEF; i++)
					sum += per_ms[i];
				pp = longint'(peak_hi) - longint'(peak_lo);
				running = 1'b0;
				if (pp * 50 > PP_X50_MIN && sum > MIN_PERIOD_MS * PERIODS_DEF) begin
					num = (64'(amp_q) * 64'd8) << 40;
					den = pp * 64'(PI_Q24);
					ku = num / den;
					if (ku > 64'hFFFF_FFFF)
						ku = 64'hFFFF_FFFF;
					gain_q = ku[31:0];
					tu_q = 16'((sum + PERIODS_DEF / 2) / PERIODS_DEF);
					o.status = STATUS_DONE;
				end else begin
					o.status = STATUS_FAIL_SMALL;
				end
			end else begin
				dt = r.stamp - run_start_ms;
				if (dt > 32'(TIMEOUT_DEF)) begin
					running = 1'b0;
					o.status = STATUS_FAIL_TIME;
				end
			end
		end
		o.gain = gain_q;
		o.tu_ms = tu_q;
		expected.push_back(o);
	endfunction

	function automatic void add_req(req_kind_t k, int e, int y, bit [31:0] t);
		tune_req_t r;
		r.kind = k;
		r.err = e[SIG_W-1:0];
		r.meas = y[SIG_W-1:0];
		r.stamp = t;
		pending.push_back(r);
		queued++;
	endfunction

	// one relay run: begin, then alternating high/low error blocks with random content
	function automatic void add_run();
		int unsigned pick;
		int unsigned step_lo;
		int unsigned step_hi;
		int unsigned blocks;
		int unsigned n;
		int          swing;
		int          mid;
		int          jit;
		int          band;
		int          e;
		int          y;
		pick = $urandom_range(0, 99);
		band = int'(hyst_q);
		mid = int'($urandom_range(0, 1 << 22)) - (1 << 21);
		swing = $urandom_range(41, 1 << 21);
		jit = swing / 8;
		step_lo = 5;
		step_hi = 400;
		if (pick < 15) begin
			// periods too short for a valid Tu
			step_lo = 1;
			step_hi = 4;
		end else if (pick < 28) begin
			// swing around the minimum amplitude threshold
			swing = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(38, 42);
			jit = 0;
		end else if (pick < 40) begin
			step_lo = 1000;
			step_hi = 9000;
		end else if (pick < 45) begin
			mid = 0;
			swing = 8388607;
			jit = 0;
		end
		if ($urandom_range(0, 9) == 0)
			gen_ms = $urandom;
		add_req(REQ_BEGIN, int'($urandom), int'($urandom), gen_ms);
		blocks = $urandom_range(6, 9);
		for (int b = 0; b < blocks; b++) begin
			for (int half = 0; half < 2; half++) begin
				n = $urandom_range(1, 3);
				for (int s = 0; s < n; s++) begin
					gen_ms += $urandom_range(step_lo, step_hi);
					if ($urandom_range(0, 199) == 0)
						gen_ms += 70000;
					y = mid + (half == 0 ? swing : -swing) + int'($urandom_range(0, 2 * jit)) - jit;
					if ($urandom_range(0, 9) == 0)
						e = int'($urandom_range(0, 2 * band)) - band;
					else if (half == 0)
						e = (band >= 8388607) ? 8388607 :
							band + 1 + int'($urandom_range(0, 8388606 - band));
					else
						e = -band - 1 - int'($urandom_range(0, 8388607 - band));
					add_req(REQ_SAMPLE, e, y, gen_ms);
				end
			end
			// broken runs: cancelled or restarted part way
			if ($urandom_range(0, 32) == 0)
				add_req(REQ_CANCEL, int'($urandom), int'($urandom), gen_ms);
			else if ($urandom_range(0, 49) == 0)
				add_req(REQ_BEGIN, int'($urandom), int'($urandom), gen_ms);
		end
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.req_type <= REQ_SAMPLE;
			req.error_value <= '0;
			req.measured_value <= '0;
			req.timestamp_ms <= '0;
		end else begin
			if (req.valid && req.ready) begin
				predict_tune(on_bus);
				accepted_reqs <= accepted_reqs + 1;
			end
			if (!req.valid || req.ready) begin
				if (pending.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
					on_bus = pending.pop_front();
					req.valid <= 1'b1;
					req.req_type <= on_bus.kind;
					req.error_value <= on_bus.err;
					req.measured_value <= on_bus.meas;
					req.timestamp_ms <= on_bus.stamp;
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the request side backs up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end else if (!hold_used && accepted_reqs >= pressure_at) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end
	end

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		tune_result_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected.size() == 0) begin
					$error("result transaction with nothing outstanding: drive %0d status %0d",
						res.drive, res.status);
					mismatches++;
				end else begin
					want = expected.pop_front();
					if (res.drive !== want.drive) begin
						$error("drive: expected %0d, got %0d", want.drive, res.drive);
						mismatches++;
					end
					if (res.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, res.status);
						mismatches++;
					end
					if (res.ultimate_gain !== want.gain) begin
						$error("ultimate_gain: expected %0d, got %0d", want.gain,
							res.ultimate_gain);
						mismatches++;
					end
					if (res.ultimate_period_ms !== want.tu_ms) begin
						$error("ultimate_period_ms: expected %0d, got %0d", want.tu_ms,
							res.ultimate_period_ms);
						mismatches++;
					end
				end
			end
			res.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	task automatic wait_quiet();
		while (pending.size() != 0 || req.valid || expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_tuning(logic [AMP_W-1:0] amp, logic [HYST_W-1:0] hyst);
		cfg.valid <= 1'b1;
		cfg.index <= CFG_DRIVE_AMP;
		cfg.data <= 32'(amp);
		do @(posedge clk); while (!cfg.ready);
		amp_q = amp;
		cfg.index <= CFG_HYST;
		cfg.data <= 32'(hyst);
		do @(posedge clk); while (!cfg.ready);
		hyst_q = hyst;
		cfg.valid <= 1'b0;
	endtask

	initial begin
		logic [AMP_W-1:0]  amp_set [CHUNKS];
		logic [HYST_W-1:0] hyst_set [CHUNKS];
		int unsigned       gap_set [CHUNKS];
		int unsigned       stall_set [CHUNKS];
		int                target;
		amp_set = '{16'hFFFF, 16'($urandom), 16'd0, 16'd1, 16'($urandom), AMP_RESET};
		hyst_set = '{23'd0, 23'($urandom_range(0, 4095)), 23'h7F_FFFF, 23'd1,
			23'($urandom_range(0, 65535)), HYST_RESET};
		gap_set = '{6, 6, 81, 81, 0, 0};
		stall_set = '{81, 81, 6, 6, 0, 0};
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_DRIVE_AMP;
		cfg.data = '0;

		// directed: idle sample and cancel at field extremes
		add_req(REQ_SAMPLE, 8388607, -8388608, 32'h0);
		add_req(REQ_CANCEL, -8388608, 8388607, 32'hFFFF_FFFF);
		// full-scale run across the time wrap, last period saturates
		gen_ms = 32'hFFFF_FF00;
		add_req(REQ_BEGIN, 0, 0, gen_ms);
		for (int b = 0; b < 7; b++) begin
			gen_ms += (b == 6) ? 70000 : 100;
			add_req(REQ_SAMPLE, 8388607, 8388607, gen_ms);
			gen_ms += 100;
			add_req(REQ_SAMPLE, -8388608, -8388608, gen_ms);
		end
		// timeout, exactly at the limit and one past it
		add_req(REQ_BEGIN, 0, 0, gen_ms);
		add_req(REQ_SAMPLE, 0, 0, gen_ms + TIMEOUT_DEF);
		add_req(REQ_SAMPLE, 0, 0, gen_ms + TIMEOUT_DEF + 1);
		// cancel during a run
		add_req(REQ_BEGIN, 0, 0, gen_ms);
		add_req(REQ_SAMPLE, -8388608, 5, gen_ms + 1);
		add_req(REQ_CANCEL, 0, 0, gen_ms + 2);
		add_req(REQ_SAMPLE, 8388607, 5, gen_ms + 3);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		wait_quiet();

		for (int c = 0; c < CHUNKS; c++) begin
			set_tuning(amp_set[c], hyst_set[c]);
			send_gap_pct = gap_set[c];
			recv_stall_pct = stall_set[c];
			if (c == 4)
				pressure_at = queued + 60;
			target = queued + CHUNK_ITEMS;
			while (queued < target) begin
				if ($urandom_range(0, 99) < 80)
					add_run();
				else
					add_req(req_kind_t'($urandom_range(0, 2)), int'($urandom), int'($urandom),
						$urandom);
			end
			wait_quiet();
		end

		if (mismatches == 0 && expected.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		while (cycles < LIMIT_CYCLES) begin
			@(posedge clk);
			cycles++;
		end
		$display("end of test: mismatches");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/rtk_pkg.sv
hw/rtl/rtk_ifs.sv
hw/rtl/rtk_div.sv
hw/rtl/rtk_dp.sv
hw/rtl/rtk_ctrl.sv
hw/rtl/relay_autotune_ku_tu_unit.sv
tb/testbench.sv
